// ----- rtl/lcdm_pkg.sv -----
// Shared types and constants for the LCD mode and line sequencer.
package lcdm_pkg;

    // Line timing
    localparam logic [8:0] DOTS_PER_LINE = 9'd456;
    localparam logic [7:0] VISIBLE_LINES = 8'd144;
    localparam logic [7:0] TOTAL_LINES   = 8'd154;
    localparam logic [8:0] SCAN_DOTS     = 9'd80;
    localparam logic [8:0] DOT_TOP       = 9'd511;

    // STAT select bit positions
    localparam int SEL_HBLANK_BIT = 3;
    localparam int SEL_VBLANK_BIT = 4;
    localparam int SEL_LYC_BIT    = 6;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_SCAN   = 2'd2,
        MODE_XFER   = 2'd3
    } t_mode;

    typedef enum logic {
        CFG_LINE_COMPARE = 1'b0,
        CFG_STAT_SELECT  = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_mode       mode;
        logic [8:0]  dot;
        logic [7:0]  line;
        logic        match;
        logic [31:0] frame;
    } t_state;

    typedef struct packed {
        t_mode       display_mode;
        logic [7:0]  current_line;
        logic        compare_match;
        logic        vblank_irq;
        logic        stat_irq;
        logic [31:0] frame_number;
    } t_result;

endpackage

// ----- rtl/lcdm_step.sv -----
// Next-state and result logic for one dot tick of the sequencer.
module lcdm_step (
    input  lcdm_pkg::t_state  i_state,
    input  logic [7:0]        i_line_compare_value,
    input  logic [7:0]        i_stat_select,
    input  logic              i_line_pixels_done,
    output lcdm_pkg::t_state  o_next,
    output lcdm_pkg::t_result o_result
);

    logic [8:0] dot_inc;
    logic [7:0] line_inc;
    logic       line_hit;
    logic       line_end;
    logic       vblank_irq;
    logic       stat_irq;

    // Saturating dot count and candidate line increment
    assign dot_inc  = (i_state.dot < lcdm_pkg::DOT_TOP) ? (i_state.dot + 9'd1) : i_state.dot;
    assign line_inc = i_state.line + 8'd1;
    assign line_hit = (line_inc == i_line_compare_value);
    assign line_end = (dot_inc >= lcdm_pkg::DOTS_PER_LINE);

    // Next state
    always_comb begin
        o_next     = i_state;
        o_next.dot = dot_inc;
        case (i_state.mode)
            lcdm_pkg::MODE_SCAN: begin
                if (dot_inc >= lcdm_pkg::SCAN_DOTS) begin
                    o_next.mode = lcdm_pkg::MODE_XFER;
                end
            end
            lcdm_pkg::MODE_XFER: begin
                // only the pixel pipeline ends transfer
                if (i_line_pixels_done) begin
                    o_next.mode = lcdm_pkg::MODE_HBLANK;
                end
            end
            lcdm_pkg::MODE_HBLANK: begin
                if (line_end) begin
                    o_next.line  = line_inc;
                    o_next.match = line_hit;
                    o_next.dot   = 9'd0;
                    if (line_inc >= lcdm_pkg::VISIBLE_LINES) begin
                        o_next.mode  = lcdm_pkg::MODE_VBLANK;
                        o_next.frame = i_state.frame + 32'd1;
                    end else begin
                        o_next.mode = lcdm_pkg::MODE_SCAN;
                    end
                end
            end
            lcdm_pkg::MODE_VBLANK: begin
                if (line_end) begin
                    // compare uses the incremented value, even on wrap
                    o_next.match = line_hit;
                    o_next.dot   = 9'd0;
                    if (line_inc >= lcdm_pkg::TOTAL_LINES) begin
                        o_next.mode = lcdm_pkg::MODE_SCAN;
                        o_next.line = 8'd0;
                    end else begin
                        o_next.line = line_inc;
                    end
                end
            end
            default: begin
                o_next = i_state;
            end
        endcase
    end

    // Interrupt pulses
    always_comb begin
        vblank_irq = (i_state.mode == lcdm_pkg::MODE_HBLANK) && line_end
                     && (line_inc >= lcdm_pkg::VISIBLE_LINES);
        stat_irq   = ((i_state.mode == lcdm_pkg::MODE_XFER) && i_line_pixels_done
                      && i_stat_select[lcdm_pkg::SEL_HBLANK_BIT])
                     || (vblank_irq && i_stat_select[lcdm_pkg::SEL_VBLANK_BIT])
                     || (((i_state.mode == lcdm_pkg::MODE_HBLANK)
                          || (i_state.mode == lcdm_pkg::MODE_VBLANK))
                         && line_end && line_hit
                         && i_stat_select[lcdm_pkg::SEL_LYC_BIT]);
    end

    // Result fields
    always_comb begin
        o_result.display_mode  = o_next.mode;
        o_result.current_line  = o_next.line;
        o_result.compare_match = o_next.match;
        o_result.vblank_irq    = vblank_irq;
        o_result.stat_irq      = stat_irq;
        o_result.frame_number  = o_next.frame;
    end

endmodule

// ----- rtl/lcdm_out_buf.sv -----
// Two-entry output buffer (result register plus skid register).
module lcdm_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lcdm_pkg::t_result i_data,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output lcdm_pkg::t_result o_data
);

    logic              r_out_valid;
    logic              r_skid_valid;
    lcdm_pkg::t_result r_out;
    lcdm_pkg::t_result r_skid;
    logic              out_load;

    assign o_space  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;
    assign out_load = !r_out_valid || i_ready;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid  <= r_skid_valid || i_push;
                r_skid_valid <= 1'b0;
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end
        if (!out_load && i_push) begin
            r_skid <= i_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while result register empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("push into full output buffer");

    a_skid_drains_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (r_out_valid && (r_out == $past(r_skid))))
        else $error("skid entry not moved to result register");
`endif

endmodule

// ----- rtl/lcd_mode_line_sequencer_unit.sv -----
// Top level of the LCD mode and line sequencer.
//
// One input transaction is one dot tick, carrying i_line_pixels_done from
// the pixel pipeline. Each accepted tick advances the mode, dot counter,
// line number, line-compare flag and frame counter, and produces exactly
// one result transaction: mode, line, compare flag, v-blank and STAT
// interrupt pulses and the frame count, all as they stand after the tick.
// Throughput: one tick per cycle while o_in_ready is high; the state
// update is a single pass of logic from the state registers back into
// them. Results go into a two-entry output buffer, so a tick is still
// taken in the cycle a result waits; if the receiver holds i_out_ready low
// for two results, o_in_ready drops until the receiver takes one of them.
// Reset (i_rst_n low, synchronous) starts OAM scan on line 0 with the dot
// and frame counters cleared, empties the buffer and clears both
// configuration registers. Configuration is written through i_cfg_we with
// no handshake; the user must write it only while the block is idle, and
// the block itself does not enforce this.
module lcd_mode_line_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_line_pixels_done,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_display_mode,
    output logic [7:0]  o_current_line,
    output logic        o_compare_match,
    output logic        o_vblank_irq,
    output logic        o_stat_irq,
    output logic [31:0] o_frame_number
);

    logic [7:0]        r_line_compare_value;
    logic [7:0]        r_stat_select;
    lcdm_pkg::t_state  r_state;
    lcdm_pkg::t_state  n_state;
    lcdm_pkg::t_result step_result;
    lcdm_pkg::t_result out_data;
    logic              in_accept;

    assign in_accept = i_in_valid && o_in_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_compare_value <= 8'd0;
            r_stat_select        <= 8'd0;
        end else if (i_cfg_we) begin
            case (lcdm_pkg::t_cfg_reg'(i_cfg_index))
                lcdm_pkg::CFG_LINE_COMPARE: r_line_compare_value <= i_cfg_data;
                lcdm_pkg::CFG_STAT_SELECT:  r_stat_select        <= i_cfg_data;
                default: begin
                    r_stat_select <= r_stat_select;
                end
            endcase
        end
    end

    // Tick logic
    lcdm_step u_step (
        .i_state              (r_state),
        .i_line_compare_value (r_line_compare_value),
        .i_stat_select        (r_stat_select),
        .i_line_pixels_done   (i_line_pixels_done),
        .o_next               (n_state),
        .o_result             (step_result)
    );

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode  <= lcdm_pkg::MODE_SCAN;
            r_state.dot   <= 9'd0;
            r_state.line  <= 8'd0;
            r_state.match <= 1'b0;
            r_state.frame <= 32'd0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Result buffer
    lcdm_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (step_result),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data)
    );

    assign o_display_mode  = out_data.display_mode;
    assign o_current_line  = out_data.current_line;
    assign o_compare_match = out_data.compare_match;
    assign o_vblank_irq    = out_data.vblank_irq;
    assign o_stat_irq      = out_data.stat_irq;
    assign o_frame_number  = out_data.frame_number;

`ifndef NO_ASSERTIONS
    a_line_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.line < lcdm_pkg::TOTAL_LINES)
        else $error("line number beyond frame");

    a_vblank_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_vblank_irq) |->
            ((o_display_mode == lcdm_pkg::MODE_VBLANK)
             && (o_current_line == lcdm_pkg::VISIBLE_LINES)))
        else $error("v-blank pulse outside v-blank entry");

    a_frame_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (r_state.mode == lcdm_pkg::MODE_XFER)) |=>
            (r_state.frame == $past(r_state.frame)))
        else $error("frame count moved during transfer");
`endif

endmodule

// ----- tb/sv/lcd_mode_line_sequencer_unit_test.sv -----
// Self-checking testbench for the LCD mode and line sequencer unit.
`timescale 1ns / 100ps

module lcd_mode_line_sequencer_unit_test;

    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_TICKS = 105;
    localparam int NUM_PHASES  = 6;
    localparam int NUM_ROWS    = 13;

    // One row of the directed table: a run of n ticks with a fixed done flag.
    // When typed is set, res is the result of the last tick of the run.
    typedef struct {
        int unsigned       n;
        logic              done;
        bit                typed;
        lcdm_pkg::t_result res;
    } t_dir_row;

    typedef struct {
        bit                typed;
        lcdm_pkg::t_result res;
    } t_tick_mark;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_data = 8'd0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_line_pixels_done = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_display_mode;
    logic [7:0]  o_current_line;
    logic        o_compare_match;
    logic        o_vblank_irq;
    logic        o_stat_irq;
    logic [31:0] o_frame_number;

    // Shadow configuration, as written to the block
    logic [7:0] cmp_line = 8'd0;
    logic [7:0] stat_sel = 8'd0;

    // Sequencer state seen by the stimulus side and by the checker
    lcdm_pkg::t_state plan_state;
    lcdm_pkg::t_state check_state;

    t_tick_mark        offered_ticks[$];
    lcdm_pkg::t_result pending_results[$];

    int  fail_count = 0;
    int  idle_cycles = 0;
    int  hold_left = 0;
    int  rx_cycles = 0;
    bit  no_idle = 1'b0;

    t_tick_mark        mon_mark;
    lcdm_pkg::t_result mon_pred;
    lcdm_pkg::t_result mon_want;

    lcd_mode_line_sequencer_unit i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_line_pixels_done (i_line_pixels_done),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_display_mode     (o_display_mode),
        .o_current_line     (o_current_line),
        .o_compare_match    (o_compare_match),
        .o_vblank_irq       (o_vblank_irq),
        .o_stat_irq         (o_stat_irq),
        .o_frame_number     (o_frame_number)
    );

    always #4 i_clk = ~i_clk;

    function automatic lcdm_pkg::t_result lcd_res(lcdm_pkg::t_mode m, int line, bit match,
                                                  bit vb, bit st, int frame);
        lcdm_pkg::t_result r;
        r.display_mode  = m;
        r.current_line  = 8'(line);
        r.compare_match = match;
        r.vblank_irq    = vb;
        r.stat_irq      = st;
        r.frame_number  = 32'(frame);
        return r;
    endfunction

    // Line increment with compare; the compare sees the raw incremented value
    function automatic void advance_line(inout lcdm_pkg::t_state st,
                                         inout lcdm_pkg::t_result r);
        st.line  = st.line + 8'd1;
        st.match = (st.line == cmp_line);
        if (st.match && stat_sel[lcdm_pkg::SEL_LYC_BIT])
            r.stat_irq = 1'b1;
    endfunction

    // Advance the sequencer by one dot and return what the block reports
    function automatic lcdm_pkg::t_result dot_tick(inout lcdm_pkg::t_state st,
                                                   input logic done);
        lcdm_pkg::t_result r;
        r = '0;
        if (st.dot != lcdm_pkg::DOT_TOP)
            st.dot = st.dot + 9'd1;
        case (st.mode)
            lcdm_pkg::MODE_SCAN: begin
                if (st.dot >= lcdm_pkg::SCAN_DOTS)
                    st.mode = lcdm_pkg::MODE_XFER;
            end
            lcdm_pkg::MODE_XFER: begin
                // transfer ignores the line end, only the pipeline flag leaves it
                if (done) begin
                    st.mode = lcdm_pkg::MODE_HBLANK;
                    if (stat_sel[lcdm_pkg::SEL_HBLANK_BIT])
                        r.stat_irq = 1'b1;
                end
            end
            lcdm_pkg::MODE_HBLANK: begin
                if (st.dot >= lcdm_pkg::DOTS_PER_LINE) begin
                    advance_line(st, r);
                    if (st.line >= lcdm_pkg::VISIBLE_LINES) begin
                        st.mode = lcdm_pkg::MODE_VBLANK;
                        r.vblank_irq = 1'b1;
                        if (stat_sel[lcdm_pkg::SEL_VBLANK_BIT])
                            r.stat_irq = 1'b1;
                        st.frame = st.frame + 32'd1;
                    end else begin
                        st.mode = lcdm_pkg::MODE_SCAN;
                    end
                    st.dot = '0;
                end
            end
            default: begin
                if (st.dot >= lcdm_pkg::DOTS_PER_LINE) begin
                    advance_line(st, r);
                    if (st.line >= lcdm_pkg::TOTAL_LINES) begin
                        st.mode = lcdm_pkg::MODE_SCAN;
                        st.line = '0;
                    end
                    st.dot = '0;
                end
            end
        endcase
        r.display_mode  = st.mode;
        r.current_line  = st.line;
        r.compare_match = st.match;
        r.frame_number  = st.frame;
        return r;
    endfunction

    // Offer one dot tick and hold it until the block takes it
    task automatic send_tick(input logic done, input bit typed,
                             input lcdm_pkg::t_result res);
        while (!no_idle && $urandom_range(0, 99) < 14) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        void'(dot_tick(plan_state, done));
        offered_ticks.push_back('{typed, res});
        i_in_valid         <= 1'b1;
        i_line_pixels_done <= done;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    // Write both registers once the block has drained
    task automatic write_cfg(input logic [7:0] cmp, input logic [7:0] sel);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0 || offered_ticks.size() != 0)
            @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= lcdm_pkg::CFG_LINE_COMPARE;
        i_cfg_data  <= cmp;
        @(posedge i_clk);
        i_cfg_index <= lcdm_pkg::CFG_STAT_SELECT;
        i_cfg_data  <= sel;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cmp_line = cmp;
        stat_sel = sel;
    endtask

    // Receiver: random stalls plus a periodic long hold-off
    always @(posedge i_clk) begin
        rx_cycles <= rx_cycles + 1;
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (rx_cycles % 1000 == 500) begin
            i_out_ready <= 1'b0;
            hold_left   <= HOLD_CYCLES;
        end else begin
            i_out_ready <= no_idle || ($urandom_range(0, 99) >= 14);
        end
    end

    // Predict on each accepted tick, check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            mon_mark = offered_ticks.pop_front();
            mon_pred = dot_tick(check_state, i_line_pixels_done);
            pending_results.push_back(mon_mark.typed ? mon_mark.res : mon_pred);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no tick pending");
                fail_count++;
            end else begin
                mon_want = pending_results.pop_front();
                if (o_display_mode !== mon_want.display_mode) begin
                    $error("display_mode: expected %0d, got %0d",
                           mon_want.display_mode, o_display_mode);
                    fail_count++;
                end
                if (o_current_line !== mon_want.current_line) begin
                    $error("current_line: expected %0d, got %0d",
                           mon_want.current_line, o_current_line);
                    fail_count++;
                end
                if (o_compare_match !== mon_want.compare_match) begin
                    $error("compare_match: expected %0d, got %0d",
                           mon_want.compare_match, o_compare_match);
                    fail_count++;
                end
                if (o_vblank_irq !== mon_want.vblank_irq) begin
                    $error("vblank_irq: expected %0d, got %0d",
                           mon_want.vblank_irq, o_vblank_irq);
                    fail_count++;
                end
                if (o_stat_irq !== mon_want.stat_irq) begin
                    $error("stat_irq: expected %0d, got %0d",
                           mon_want.stat_irq, o_stat_irq);
                    fail_count++;
                end
                if (o_frame_number !== mon_want.frame_number) begin
                    $error("frame_number: expected %0d, got %0d",
                           mon_want.frame_number, o_frame_number);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_dir_row   dir_rows[NUM_ROWS];
        logic [7:0] phase_cmp[NUM_PHASES];
        logic [7:0] phase_sel[NUM_PHASES];
        logic       done;
        bit         in_xfer;
        int         xfer_goal;
        int         xfer_len;
        int         pick;

        plan_state      = '0;
        plan_state.mode = lcdm_pkg::MODE_SCAN;
        check_state     = plan_state;
        in_xfer         = 1'b0;
        xfer_goal       = 0;
        xfer_len        = 0;

        // Walk through one line, then a hung transfer that saturates the dot counter
        dir_rows = '{
            '{1,   1'b1, 1'b1, lcd_res(lcdm_pkg::MODE_SCAN,   0, 0, 0, 0, 0)},
            '{78,  1'b1, 1'b1, lcd_res(lcdm_pkg::MODE_SCAN,   0, 0, 0, 0, 0)},
            '{1,   1'b0, 1'b1, lcd_res(lcdm_pkg::MODE_XFER,   0, 0, 0, 0, 0)},
            '{100, 1'b0, 1'b1, lcd_res(lcdm_pkg::MODE_XFER,   0, 0, 0, 0, 0)},
            '{1,   1'b1, 1'b1, lcd_res(lcdm_pkg::MODE_HBLANK, 0, 0, 0, 1, 0)},
            '{1,   1'b0, 1'b1, lcd_res(lcdm_pkg::MODE_HBLANK, 0, 0, 0, 0, 0)},
            '{273, 1'b1, 1'b0, '0},
            '{1,   1'b0, 1'b1, lcd_res(lcdm_pkg::MODE_SCAN,   1, 1, 0, 1, 0)},
            '{80,  1'b0, 1'b1, lcd_res(lcdm_pkg::MODE_XFER,   1, 1, 0, 0, 0)},
            '{431, 1'b0, 1'b0, '0},
            '{50,  1'b0, 1'b1, lcd_res(lcdm_pkg::MODE_XFER,   1, 1, 0, 0, 0)},
            '{1,   1'b1, 1'b1, lcd_res(lcdm_pkg::MODE_HBLANK, 1, 1, 0, 1, 0)},
            '{1,   1'b0, 1'b1, lcd_res(lcdm_pkg::MODE_SCAN,   2, 0, 0, 0, 0)}
        };

        // Compare values that never hit here, one that hits the next line end, and random
        phase_cmp = '{8'd154, 8'd144, 8'd255, 8'd0, 8'd3, 8'($urandom_range(0, 255))};
        phase_sel = '{8'h40, 8'hFF, 8'h00, 8'hBF, 8'($urandom_range(0, 255)), 8'h18};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part; the hung transfer runs with no random idling on either side
        write_cfg(8'd1, 8'hFF);
        foreach (dir_rows[r]) begin
            no_idle = (r >= 8) && (r <= 11);
            for (int k = 0; k < dir_rows[r].n; k++)
                send_tick(dir_rows[r].done, dir_rows[r].typed && (k == dir_rows[r].n - 1),
                          dir_rows[r].res);
        end
        no_idle = 1'b0;

        // Random part: a run of dots per setting
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_cfg(phase_cmp[p], phase_sel[p]);
            for (int t = 0; t < PHASE_TICKS; t++) begin
                if (plan_state.mode == lcdm_pkg::MODE_XFER) begin
                    // mostly clean transfers; some noisy flags, a few hung lines
                    if (!in_xfer) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 5)
                            xfer_goal = $urandom_range(432, 640);
                        else if (pick < 15)
                            xfer_goal = -1;
                        else
                            xfer_goal = $urandom_range(1, 375);
                        xfer_len = 0;
                    end
                    in_xfer  = 1'b1;
                    xfer_len = xfer_len + 1;
                    if (xfer_goal < 0)
                        done = 1'($urandom_range(0, 1));
                    else
                        done = (xfer_len >= xfer_goal);
                end else begin
                    in_xfer = 1'b0;
                    done    = 1'($urandom_range(0, 1));
                end
                send_tick(done, 1'b0, '0);
            end
        end

        // Drain
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0 || offered_ticks.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/lcdm_pkg.sv
rtl/lcdm_step.sv
rtl/lcdm_out_buf.sv
rtl/lcd_mode_line_sequencer_unit.sv
tb/sv/lcd_mode_line_sequencer_unit_test.sv
